// ----- rtl/tccw_pkg.sv -----
// Package for the text console character writer.
// Holds screen geometry, cell and control-code constants, the sequencer state type
// and the screen store request bundle. No dependencies.
package tccw_pkg;

    localparam int MAX_COLS   = 80;
    localparam int MAX_ROWS   = 50;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int CELL_AW    = $clog2(CELL_COUNT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int HW_W   = 12;
    localparam int CELL_W = 16;
    localparam int PROD_W = COL_W + ROW_W;

    localparam logic [COL_W-1:0]  COLS_RESET = COL_W'(80);
    localparam logic [ROW_W-1:0]  ROWS_RESET = ROW_W'(50);
    localparam logic [7:0]        ATTR_RESET = 8'h07;
    localparam logic [COL_W-1:0]  COLS_MAX   = COL_W'(MAX_COLS);
    localparam logic [ROW_W-1:0]  ROWS_MAX   = ROW_W'(MAX_ROWS);
    localparam logic [ROW_W-1:0]  ROWS_MIN   = ROW_W'(3);
    localparam logic [COL_W-1:0]  HW_PITCH   = COL_W'(80);
    localparam logic [COL_W-1:0]  TAB_MASK   = ~COL_W'(3);
    localparam logic [COL_W-1:0]  TAB_STEP   = COL_W'(4);

    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;
    localparam logic [7:0]        BLANK_CHAR = 8'h20;

    // Control codes, compared on the full 16-bit code.
    localparam logic [15:0] CH_NONE = 16'h0000;
    localparam logic [15:0] CH_BS   = 16'h0008;
    localparam logic [15:0] CH_TAB  = 16'h0009;
    localparam logic [15:0] CH_NL   = 16'h000A;
    localparam logic [15:0] CH_CR   = 16'h000D;

    // Commands carried in tuser.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_COLUMNS   = 2'd0;
    localparam logic [1:0] REG_ROWS      = 2'd1;
    localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SETUP,
        ST_WRAP,
        ST_CHECK,
        ST_COPY,
        ST_COPY_END,
        ST_FILL,
        ST_ACT,
        ST_MUL_ADDR,
        ST_WRITE,
        ST_HW_MUL,
        ST_HW_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [CELL_AW-1:0] waddr;
        logic [CELL_W-1:0]  wdata;
        logic [CELL_AW-1:0] raddr;
    } t_mem_req;

endpackage

// ----- rtl/text_console_char_writer_top.sv -----
// Top level of the text console character writer.
// Depends on tccw_pkg and instantiates the screen store tccw_screen_mem.
//
// Usage: items arrive on the s_axis channel, one character or one read command per
// transfer, and each item yields exactly one result transfer on m_axis. A put writes
// the character at the cursor or moves the cursor for the control codes newline,
// carriage return, backspace and tab; tlast on a put latches the hardware cursor
// offset row*80+col. A read returns one stored cell. Configuration registers (columns,
// rows, attribute) are written through the cfg port, by the user only while the block
// is idle; the block itself does not enforce this. A read passes the address and data
// states, a zero code goes straight to the result, a control code passes setup, wrap,
// check and act, a plain character also the row multiply and the write, and tlast on a
// put adds the offset multiply and sum. All offsets come from one shared small
// multiplier. A scroll copies the visible screen through the store at one cell per
// cycle. Only one item is in work at a time; s_axis_tready is high only while the
// sequencer is idle. Reset: the cursor and the latched offset clear, the registers go
// to 80, 50 and 7, and a clearing pass writes a space with attribute 07 into all 4000
// cells, during which no item is accepted (configuration writes still are).
// Stall: the result sits in an output register; the next item is accepted and worked
// on meanwhile, and the sequencer waits only when a second result is ready.
module text_console_char_writer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] char_code, [27:16] cell_index, zero fill
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    input  logic        s_axis_tlast,   // last_char
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [6:0] cursor_col, [12:7] cursor_row,
                                        // [24:13] hw_cursor_offset, [40:25] read_data
);
    import tccw_pkg::*;

    // Configuration registers.
    logic [COL_W-1:0] r_screen_columns;
    logic [ROW_W-1:0] r_screen_rows;
    logic [7:0]       r_text_attribute;

    // Sequencer and working registers.
    t_state             r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [15:0]        r_code, n_code;
    logic               r_last, n_last;
    logic [11:0]        r_idx, n_idx;
    logic [COL_W-1:0]   r_cols, n_cols;
    logic [ROW_W-1:0]   r_rows, n_rows;
    logic [CELL_AW-1:0] r_end, n_end;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [CELL_AW-1:0] r_src, n_src;
    logic [CELL_AW-1:0] r_waddr, n_waddr;
    logic               r_wpend, n_wpend;
    logic               r_phase, n_phase;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [HW_W-1:0]    r_hw, n_hw;
    logic [CELL_W-1:0]  r_rdata, n_rdata;
    logic               r_out_valid, n_out_valid;
    logic [47:0]        r_out_data, n_out_data;

    t_mem_req           mem_req;
    logic [CELL_W-1:0]  mem_q;

    // Shared multiplier operands.
    logic [COL_W-1:0]   mul_a;
    logic [ROW_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;

    // Clamped geometry taken at accept time.
    logic [COL_W-1:0]   eff_cols;
    logic [ROW_W-1:0]   eff_rows;
    logic [15:0]        in_code;
    logic [11:0]        in_idx;
    logic               idx_ok;
    logic [CELL_W-1:0]  blank_cell;

    assign in_code    = s_axis_tdata[15:0];
    assign in_idx     = s_axis_tdata[27:16];
    assign idx_ok     = (r_idx < 12'(CELL_COUNT));
    assign blank_cell = {r_text_attribute, BLANK_CHAR};

    always_comb begin
        eff_cols = r_screen_columns;
        if (r_screen_columns == '0) begin
            eff_cols = COL_W'(1);
        end else if (r_screen_columns > COLS_MAX) begin
            eff_cols = COLS_MAX;
        end
        eff_rows = r_screen_rows;
        if (r_screen_rows < ROWS_MIN) begin
            eff_rows = ROWS_MIN;
        end else if (r_screen_rows > ROWS_MAX) begin
            eff_rows = ROWS_MAX;
        end
    end

    // The one multiplier: screen size at setup, row base for a cell write,
    // and row times the fixed display pitch for the hardware cursor.
    assign mul_a = (r_state == ST_HW_MUL) ? HW_PITCH : r_cols;
    assign mul_b = (r_state == ST_SETUP) ? (r_rows - ROW_W'(1)) : r_row;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    tccw_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_columns <= COLS_RESET;
            r_screen_rows    <= ROWS_RESET;
            r_text_attribute <= ATTR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COLUMNS:   r_screen_columns <= i_cfg_wdata[COL_W-1:0];
                REG_ROWS:      r_screen_rows    <= i_cfg_wdata[ROW_W-1:0];
                REG_ATTRIBUTE: r_text_attribute <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_src       <= '0;
            r_wpend     <= 1'b0;
            r_phase     <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_src       <= n_src;
            r_wpend     <= n_wpend;
            r_phase     <= n_phase;
            r_col       <= n_col;
            r_row       <= n_row;
            r_hw        <= n_hw;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_code     <= n_code;
        r_last     <= n_last;
        r_idx      <= n_idx;
        r_cols     <= n_cols;
        r_rows     <= n_rows;
        r_end      <= n_end;
        r_prod     <= n_prod;
        r_waddr    <= n_waddr;
        r_rdata    <= n_rdata;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_code      = r_code;
        n_last      = r_last;
        n_idx       = r_idx;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_end       = r_end;
        n_prod      = r_prod;
        n_src       = r_src;
        n_waddr     = r_waddr;
        n_wpend     = r_wpend;
        n_phase     = r_phase;
        n_col       = r_col;
        n_row       = r_row;
        n_hw        = r_hw;
        n_rdata     = r_rdata;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid & ~m_axis_tready;

        mem_req       = '0;
        mem_req.raddr = r_src;

        s_axis_tready = (r_state == ST_IDLE);

        case (r_state)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_src;
                mem_req.wdata = CELL_RESET;
                n_src         = r_src + CELL_AW'(1);
                if (r_src == CELL_AW'(CELL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser[0];
                    n_code  = in_code;
                    n_last  = s_axis_tlast;
                    n_idx   = in_idx;
                    n_cols  = eff_cols;
                    n_rows  = eff_rows;
                    n_phase = 1'b0;
                    n_rdata = '0;
                    if (s_axis_tuser[0] == CMD_READ) begin
                        n_state = ST_RD_ADDR;
                    end else if (in_code == CH_NONE) begin
                        n_state = s_axis_tlast ? ST_HW_MUL : ST_DONE;
                    end else begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_RD_ADDR: begin
                mem_req.raddr = idx_ok ? CELL_AW'(r_idx) : '0;
                n_state       = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_rdata = idx_ok ? mem_q : '0;
                n_state = ST_DONE;
            end
            ST_SETUP: begin
                // End of the scrolled area: columns * (rows - 1).
                n_prod  = mul_p;
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                if (r_phase == 1'b0) begin
                    n_end = CELL_AW'(r_prod);
                end
                if (r_col >= r_cols) begin
                    n_col = '0;
                    n_row = r_row + ROW_W'(1);
                end
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_row >= (r_rows - ROW_W'(1))) begin
                    n_src   = CELL_AW'(r_cols);
                    n_wpend = 1'b0;
                    n_state = ST_COPY;
                end else if (r_phase == 1'b0) begin
                    n_state = ST_ACT;
                end else if (r_last) begin
                    n_state = ST_HW_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_COPY: begin
                // Read one cell per cycle; write the cell read in the previous cycle
                // one row higher.
                mem_req.raddr = r_src;
                mem_req.we    = r_wpend;
                mem_req.waddr = r_waddr;
                mem_req.wdata = mem_q;
                n_waddr       = r_src - CELL_AW'(r_cols);
                n_wpend       = 1'b1;
                n_src         = r_src + CELL_AW'(1);
                if (r_src == r_end - CELL_AW'(1)) begin
                    n_state = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_waddr;
                mem_req.wdata = mem_q;
                n_wpend       = 1'b0;
                n_src         = r_end - CELL_AW'(r_cols);
                n_state       = ST_FILL;
            end
            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_src;
                mem_req.wdata = blank_cell;
                n_src         = r_src + CELL_AW'(1);
                if (r_src == r_end - CELL_AW'(1)) begin
                    n_row   = r_row - ROW_W'(1);
                    n_state = ST_CHECK;
                end
            end
            ST_ACT: begin
                n_phase = 1'b1;
                n_state = ST_WRAP;
                case (r_code)
                    CH_NL: begin
                        n_row = r_row + ROW_W'(1);
                        n_col = '0;
                    end
                    CH_CR: begin
                        n_col = '0;
                    end
                    CH_BS: begin
                        if (r_col != '0) begin
                            n_col = r_col - COL_W'(1);
                        end
                    end
                    CH_TAB: begin
                        n_col = (r_col + TAB_STEP) & TAB_MASK;
                    end
                    default: begin
                        n_phase = 1'b0;
                        n_state = ST_MUL_ADDR;
                    end
                endcase
            end
            ST_MUL_ADDR: begin
                n_prod  = mul_p;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = CELL_AW'(r_prod) + CELL_AW'(r_col);
                mem_req.wdata = {r_text_attribute, r_code[7:0]};
                n_col         = r_col + COL_W'(1);
                n_phase       = 1'b1;
                n_state       = ST_WRAP;
            end
            ST_HW_MUL: begin
                n_prod  = mul_p;
                n_state = ST_HW_SUM;
            end
            ST_HW_SUM: begin
                n_hw    = HW_W'(r_prod) + HW_W'(r_col);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'b0, r_rdata, r_hw, r_row, r_col};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/tccw_screen_mem.sv -----
// Screen cell store: one write port and one read port with registered read data.
// Depends on tccw_pkg for the depth, the widths and the request bundle.
module tccw_screen_mem (
    input  logic                           i_clk,
    input  tccw_pkg::t_mem_req             i_req,
    output logic [tccw_pkg::CELL_W-1:0]    o_rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] r_cells [CELL_COUNT];
    logic [CELL_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_cells[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_cells[i_req.raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- tb/text_console_char_writer_top_tb.sv -----
// Self-checking testbench for text_console_char_writer_top.
// Depends on tccw_pkg and the RTL only; a scoreboard class tracks the screen store,
// the cursor and the latched offset, and checks every result transfer.
`timescale 1ns / 100ps

module text_console_char_writer_top_tb;
    import tccw_pkg::*;

    // The limit covers the clearing pass, about 1270 items with both sides idling, a few
    // hundred scroll steps on small screens and a few dozen on wide but short screens,
    // several times over.
    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 78;
    localparam int DRAIN_CYCLES    = 64;
    localparam int MAX_PRINTED     = 40;

    // One result transfer, packed the way it travels in m_axis_tdata[40:0].
    typedef struct packed {
        logic [15:0] read_data;
        logic [11:0] hw_offset;
        logic [5:0]  cursor_row;
        logic [6:0]  cursor_col;
    } console_status_t;

    // Tracks the screen store, cursor, latched offset and registers, and holds the
    // status words still owed by the block, oldest first.
    class screen_tracker;
        logic [15:0]     cells [CELL_COUNT];
        int unsigned     col;
        int unsigned     row;
        int unsigned     hw_offset;
        logic [6:0]      columns_reg;
        logic [5:0]      rows_reg;
        logic [7:0]      attr_reg;
        console_status_t owed_status[$];
        int unsigned     mismatches;

        function new();
            foreach (cells[i]) cells[i] = CELL_RESET;
            col         = 0;
            row         = 0;
            hw_offset   = 0;
            columns_reg = COLS_RESET;
            rows_reg    = ROWS_RESET;
            attr_reg    = ATTR_RESET;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_COLUMNS:   columns_reg = value[6:0];
                REG_ROWS:      rows_reg    = value[5:0];
                REG_ATTRIBUTE: attr_reg    = value;
                default: ;
            endcase
        endfunction

        // Register values are clamped to the range the store can hold.
        function int unsigned used_cols();
            if (columns_reg < 1) return 1;
            if (columns_reg > MAX_COLS) return MAX_COLS;
            return columns_reg;
        endfunction

        function int unsigned used_rows();
            if (rows_reg < ROWS_MIN) return ROWS_MIN;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int unsigned pending();
            return owed_status.size();
        endfunction

        // Wrap a column past the edge, then scroll until the cursor sits above the
        // reserved bottom row. Each scroll step moves rows 1..rows-2 up by one and
        // blanks row rows-2 with the current attribute.
        function void settle_cursor(int unsigned cols, int unsigned rows);
            if (col >= cols) begin
                col = 0;
                row++;
            end
            while (row >= rows - 1) begin
                for (int unsigned i = 0; i < cols * (rows - 2); i++)
                    cells[i] = cells[i + cols];
                for (int unsigned i = 0; i < cols; i++)
                    cells[cols * (rows - 2) + i] = {attr_reg, BLANK_CHAR};
                row--;
            end
        endfunction

        // Apply one accepted item and queue the status word it must produce.
        function void take_item(logic cmd, logic [15:0] code, logic last,
                                logic [11:0] index);
            int unsigned     cols;
            int unsigned     rows;
            int unsigned     addr;
            logic [15:0]     rdata;
            console_status_t status;
            rdata = '0;
            if (cmd == CMD_READ) begin
                // A read never moves the cursor and never latches, tlast or not.
                if (index < CELL_COUNT) rdata = cells[index];
            end else begin
                cols = used_cols();
                rows = used_rows();
                if (code != CH_NONE) begin
                    settle_cursor(cols, rows);
                    case (code)
                        CH_NL: begin
                            row++;
                            col = 0;
                        end
                        CH_CR: col = 0;
                        CH_BS: if (col > 0) col--;
                        CH_TAB: col = (col + TAB_STEP) & TAB_MASK;
                        default: begin
                            // Only the low byte is stored, under the attribute.
                            addr = col + row * cols;
                            if (addr < CELL_COUNT) cells[addr] = {attr_reg, code[7:0]};
                            col++;
                        end
                    endcase
                    settle_cursor(cols, rows);
                end
                // The zero code still latches when it closes a string.
                if (last) hw_offset = (row * HW_PITCH + col) & 12'hFFF;
            end
            status.read_data  = rdata;
            status.hw_offset  = hw_offset[11:0];
            status.cursor_row = row[5:0];
            status.cursor_col = col[6:0];
            owed_status.push_back(status);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            if (mismatches < MAX_PRINTED)
                $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                         $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [47:0] data);
            console_status_t got;
            console_status_t want;
            got = console_status_t'(data[40:0]);
            if (owed_status.size() == 0) begin
                report_mismatch("unexpected result", data, 0);
            end else begin
                want = owed_status.pop_front();
                if (got.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
                if (got.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
                if (got.hw_offset !== want.hw_offset)
                    report_mismatch("hw_cursor_offset", got.hw_offset, want.hw_offset);
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    screen_tracker tracker = new();

    // Idling percentages of the current phase: gaps before an input transfer and
    // cycles with the result side not ready.
    int unsigned send_gap_pct     = 0;
    int unsigned result_stall_pct = 0;
    int unsigned cycle_count      = 0;

    text_console_char_writer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock; the first transition is a falling one so no edge fires at time 0.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure, and both monitors. Every value read here
    // is the one present before the edge, since all drivers use nonblocking writes.
    // The result check runs first so an item accepted at the same edge as an older
    // result never gets in front of it.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= result_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            tracker.take_item(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tlast,
                              s_axis_tdata[27:16]);
    end

    // Present one item and hold it until the transfer happens. tvalid is lowered
    // only inside a gap, so back-to-back items keep it high without a glitch; the
    // caller lowers it once the last item of a burst is taken.
    task push_item(logic cmd, logic [15:0] code, logic last, logic [11:0] index);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'b0, index, code};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every owed result has been taken. The first edge
    // lets the input monitor note the final transfer before the count is read.
    task drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // Write all three registers on consecutive edges; only called while idle.
    task write_registers(logic [7:0] columns, logic [7:0] rows, logic [7:0] attr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_COLUMNS;
        i_cfg_wdata <= columns;
        tracker.set_reg(REG_COLUMNS, columns);
        @(posedge i_clk);
        i_cfg_index <= REG_ROWS;
        i_cfg_wdata <= rows;
        tracker.set_reg(REG_ROWS, rows);
        @(posedge i_clk);
        i_cfg_index <= REG_ATTRIBUTE;
        i_cfg_wdata <= attr;
        tracker.set_reg(REG_ATTRIBUTE, attr);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned pick;
        int unsigned span;
        logic        cmd;
        logic [15:0] code;
        logic        last;
        logic [11:0] index;

        // Every input is known from time zero, with reset asserted first.
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_COLUMNS;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_PUT;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset geometry of 80 by 50 with attribute 07. The
        // block runs its clearing pass first; push_item simply waits for tready.
        push_item(CMD_PUT, CH_NONE, 1'b1, 12'hFFF);   // zero code still latches
        push_item(CMD_PUT, 16'h0048, 1'b0, 12'h000);
        push_item(CMD_PUT, 16'hFF41, 1'b0, 12'h000);  // only the low byte is kept
        push_item(CMD_PUT, 16'h00FF, 1'b0, 12'h000);
        push_item(CMD_PUT, 16'h010A, 1'b0, 12'h000);  // not a newline: high byte set
        push_item(CMD_PUT, CH_TAB, 1'b0, 12'h000);
        push_item(CMD_PUT, 16'h0109, 1'b0, 12'h000);  // not a tab either
        push_item(CMD_PUT, CH_BS, 1'b1, 12'h000);
        push_item(CMD_PUT, CH_CR, 1'b0, 12'h000);
        push_item(CMD_PUT, CH_BS, 1'b0, 12'h000);     // backspace at column zero
        push_item(CMD_PUT, CH_NL, 1'b1, 12'h000);
        push_item(CMD_PUT, 16'hFFFF, 1'b1, 12'hFFF);
        push_item(CMD_PUT, 16'h0000, 1'b0, 12'h000);
        push_item(CMD_READ, 16'h0000, 1'b0, 12'd0);
        push_item(CMD_READ, 16'hFFFF, 1'b0, 12'd1);
        push_item(CMD_READ, 16'h0000, 1'b0, 12'd80);
        push_item(CMD_READ, 16'h0000, 1'b0, 12'd3999);  // last cell of the store
        push_item(CMD_READ, 16'h0000, 1'b1, 12'd4000);  // past the store, tlast ignored
        push_item(CMD_READ, 16'hA5A5, 1'b1, 12'hFFF);
        push_item(CMD_PUT, CH_TAB, 1'b0, 12'h000);
        push_item(CMD_PUT, CH_TAB, 1'b1, 12'h000);
        drain_results();

        // Random part in phases. Each phase sets the geometry and attribute while
        // the block is idle and picks an idling mode. The cursor carries over from
        // the previous phase, so a smaller screen starts with the cursor out of
        // range and the next put wraps and scrolls it back inside.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: ;                                                  // reset values
                1: write_registers(8'd80, 8'd3, 8'hFF);
                2: write_registers(8'd1, 8'd3, 8'h00);
                3: write_registers(8'h80, 8'hC0, 8'h5A);              // zeros, clamped
                4: write_registers(8'd4, 8'd63, 8'hA5);               // rows clamp to 50
                5: write_registers(8'd127, 8'd4, 8'($urandom_range(255)));
                6: write_registers(8'd80, 8'd50, 8'h07);
                default: write_registers(8'($urandom_range(24, 1)),
                                         8'($urandom_range(12, 3)),
                                         8'($urandom_range(255)));
            endcase

            case (p % 4)
                0: begin
                    send_gap_pct     = 0;
                    result_stall_pct = 0;
                end
                1: begin
                    send_gap_pct     = 59;
                    result_stall_pct = 0;
                end
                2: begin
                    send_gap_pct     = 0;
                    result_stall_pct = 59;
                end
                default: begin
                    send_gap_pct     = 28;
                    result_stall_pct = 28;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd   = ($urandom_range(99) < 20) ? CMD_READ : CMD_PUT;
                code  = 16'($urandom_range(16'hFFFF));
                index = 12'($urandom_range(12'hFFF));
                if (cmd == CMD_READ) begin
                    // Mostly cells on the visible screen, some anywhere, a few
                    // past the end of the store.
                    last = ($urandom_range(7) == 0);
                    pick = $urandom_range(99);
                    span = tracker.used_cols() * tracker.used_rows();
                    if (pick < 70)
                        index = 12'($urandom_range(span - 1));
                    else if (pick < 90)
                        index = 12'($urandom_range(CELL_COUNT - 1));
                end else begin
                    // Text with the usual sprinkling of control codes; a tail of
                    // fully random codes reaches every bit of char_code.
                    last = ($urandom_range(3) == 0);
                    pick = $urandom_range(99);
                    if (pick < 60)
                        code = {($urandom_range(9) < 7) ? 8'h00 : 8'($urandom_range(255)),
                                8'($urandom_range(8'h7E, 8'h20))};
                    else if (pick < 70)
                        code = CH_NL;
                    else if (pick < 75)
                        code = CH_CR;
                    else if (pick < 80)
                        code = CH_BS;
                    else if (pick < 86)
                        code = CH_TAB;
                    else if (pick < 88)
                        code = CH_NONE;
                end
                push_item(cmd, code, last, index);
            end
            drain_results();
        end

        // Give the block time to show any stray result before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
